// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the shortest covering window finder RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a plain condition at every clock edge outside reset.
`define SCWF_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("scwf: invariant violated");

// Check that a trigger implies a condition in the same cycle.
`define SCWF_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("scwf: implication violated");

`else

`define SCWF_ASSERT(label, cond)
`define SCWF_ASSERT_IMPL(label, pre, post)

`endif

`endif

// ----- hw/rtl/scwf_pkg.sv -----
// Package for the shortest covering window finder: defaults, field widths,
// status and register codes, and the count store control type. No dependencies.
package scwf_pkg;

    localparam int unsigned ALPHABET_DEF     = 256;
    localparam int unsigned BUFFER_DEPTH_DEF = 1024;
    localparam int unsigned MAX_LENGTH_DEF   = 65536;
    localparam int unsigned MAX_SET_DEF      = 8;

    localparam int unsigned SYMBOL_W   = 8;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned START_W    = 16;
    localparam int unsigned LENGTH_W   = 17;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned SET_SLOTS  = 8;
    localparam int unsigned SIZE_W     = 4;
    localparam int unsigned MATCH_W    = 4;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 4;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_NONE     = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        REG_SET_CHARS = 1'b0,
        REG_SET_SIZE  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic wr_en;
        logic clear;
    } cnt_ctrl_t;

endpackage

// ----- hw/rtl/shortest_covering_window_finder.sv -----
// Shortest covering window finder: top level with sequencer and window ring.
// Depends on scwf_pkg, scwf_count_store and assert_macros.svh.
//
// The block scans a byte string, one symbol per request on the slave stream,
// and on the request flagged with tlast returns one result on the master
// stream: the earliest shortest window that holds every character of the
// configured multiset, no window, or overflow. One item is handled at a time
// and s_tready is low while it is worked on. An item whose window is not yet
// covered goes through S_ADD and S_DONE; a covered item then repeats S_SCAN,
// S_FETCH and S_CHECK for each byte dropped from the left edge, as each drop
// takes one read of the window ring and one read-modify-write of the shared
// count memory, and ends in S_BEST and S_DONE; an item after overflow goes
// straight to S_DONE. Each byte is dropped at most once.
// Counts are cleared
// through per-entry valid flops, so there is no clearing pass after reset,
// after a result or after a register write. Registers: set_chars at byte
// address 0 (eight packed characters, lowest byte first), set_size at 8
// (duplicates counted, clamped to MAX_SET). Any register write clears the
// string in progress. The result register frees the input side, so a new
// string can start while the last result waits to be taken.
`include "assert_macros.svh"

module shortest_covering_window_finder #(
    parameter int unsigned ALPHABET     = scwf_pkg::ALPHABET_DEF,
    parameter int unsigned BUFFER_DEPTH = scwf_pkg::BUFFER_DEPTH_DEF,
    parameter int unsigned MAX_LENGTH   = scwf_pkg::MAX_LENGTH_DEF,
    parameter int unsigned MAX_SET      = scwf_pkg::MAX_SET_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [scwf_pkg::SYMBOL_W-1:0]       s_tdata,   // [7:0] symbol
    input  logic                                s_tlast,   // last_symbol
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [17:2] window_start, [34:18] window_length, rest zero
    output logic [scwf_pkg::OUT_DATA_W-1:0]     m_tdata,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scwf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [scwf_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [scwf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int unsigned SYM_W    = $clog2(ALPHABET);
    localparam int unsigned PTR_W    = $clog2(BUFFER_DEPTH);
    localparam int unsigned LEN_W    = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned POS_W    = $clog2(MAX_LENGTH + 1);
    localparam int unsigned SIZE_W   = scwf_pkg::SIZE_W;
    localparam int unsigned MATCH_W  = scwf_pkg::MATCH_W;
    localparam int unsigned START_W  = scwf_pkg::START_W;
    localparam int unsigned LENGTH_W = scwf_pkg::LENGTH_W;
    localparam int unsigned SLOTS    = scwf_pkg::SET_SLOTS;

    localparam logic [LEN_W-1:0]    DEPTH_LEN = LEN_W'(BUFFER_DEPTH);
    localparam logic [PTR_W-1:0]    PTR_LAST  = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [POS_W-1:0]    POS_LIMIT = POS_W'(MAX_LENGTH);
    localparam logic [SIZE_W-1:0]   SET_LIMIT = SIZE_W'(MAX_SET);
    localparam logic [LENGTH_W-1:0] LEN_NONE  = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_FETCH,
        S_CHECK,
        S_BEST,
        S_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Symbol reduction table: byte value modulo the alphabet size.
    // ------------------------------------------------------------------
    logic [SYM_W-1:0] sym_mod_lut [256];

    for (genvar gi = 0; gi < 256; gi++)
    begin : g_mod_lut
        localparam int unsigned MOD_VAL = gi % ALPHABET;
        assign sym_mod_lut[gi] = SYM_W'(MOD_VAL);
    end

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic                          cfg_wr;
    scwf_pkg::reg_idx_t            cfg_sel;
    logic [scwf_pkg::CFG_DATA_W-1:0] set_chars_reg;
    logic [SIZE_W-1:0]             set_size_reg;
    logic [SIZE_W-1:0]             eff_size_reg;
    logic [SYM_W-1:0]              chars_mod_reg [SLOTS];

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = scwf_pkg::reg_idx_t'(paddr[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_chars_reg <= '0;
            set_size_reg  <= '0;
            eff_size_reg  <= '0;
            for (int k = 0; k < SLOTS; k++)
            begin
                chars_mod_reg[k] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                scwf_pkg::REG_SET_CHARS:
                begin
                    set_chars_reg <= pwdata;
                    // keep the reduced characters ready for the match compare
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        chars_mod_reg[k] <= sym_mod_lut[pwdata[8*k +: 8]];
                    end
                end
                scwf_pkg::REG_SET_SIZE:
                begin
                    set_size_reg <= pwdata[SIZE_W-1:0];
                    eff_size_reg <= (pwdata[SIZE_W-1:0] > SET_LIMIT) ?
                                    SET_LIMIT : pwdata[SIZE_W-1:0];
                end
                default:
                begin
                    set_size_reg <= set_size_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            scwf_pkg::REG_SET_CHARS: prdata = set_chars_reg;
            scwf_pkg::REG_SET_SIZE:  prdata = scwf_pkg::CFG_DATA_W'(set_size_reg);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stream state
    // ------------------------------------------------------------------
    state_t                state_reg;
    logic [SYM_W-1:0]      sym_reg;
    logic                  last_reg;
    logic [POS_W-1:0]      position_reg;
    logic [POS_W-1:0]      left_edge_reg;
    logic [LEN_W-1:0]      win_len_reg;
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [MATCH_W-1:0]    matched_reg;
    logic [START_W-1:0]    best_start_reg;
    logic [LENGTH_W-1:0]   best_len_reg;
    logic                  overflowed_reg;

    logic                  out_valid_reg;
    scwf_pkg::status_t     out_status_reg;
    logic [START_W-1:0]    out_start_reg;
    logic [LENGTH_W-1:0]   out_len_reg;

    // ------------------------------------------------------------------
    // Window ring: one write per accepted byte that does not overflow, one
    // registered read at the left edge every cycle.
    // ------------------------------------------------------------------
    logic [SYM_W-1:0] win_mem [BUFFER_DEPTH];
    logic [SYM_W-1:0] byte_reg;
    logic [SYM_W-1:0] sym_in;
    logic             accept;
    logic             ovf_now;

    assign sym_in   = sym_mod_lut[s_tdata];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    // a byte that would run past the ring or the position range overflows
    assign ovf_now  = overflowed_reg || (position_reg >= POS_LIMIT) ||
                      (win_len_reg >= DEPTH_LEN);

    always_ff @(posedge clk)
    begin
        if (accept && !ovf_now)
        begin
            win_mem[wr_ptr_reg] <= sym_in;
        end
        byte_reg <= win_mem[rd_ptr_reg];
    end

    // ------------------------------------------------------------------
    // Shared compare unit: count the set slots equal to the current symbol
    // (new byte while adding, left-edge byte while scanning).
    // ------------------------------------------------------------------
    logic [SYM_W-1:0]   need_char;
    logic [MATCH_W-1:0] need_cnt;

    assign need_char = (state_reg == S_ADD) ? sym_reg : byte_reg;

    always_comb
    begin
        need_cnt = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if ((SIZE_W'(k) < eff_size_reg) && (chars_mod_reg[k] == need_char))
            begin
                need_cnt = need_cnt + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Count memory and its update arithmetic
    // ------------------------------------------------------------------
    scwf_pkg::cnt_ctrl_t cnt_ctrl;
    logic [SYM_W-1:0]    cnt_rd_addr;
    logic [SYM_W-1:0]    cnt_wr_addr;
    logic [LEN_W-1:0]    cnt_wr_data;
    logic [LEN_W-1:0]    cnt_rd_data;
    logic [LEN_W-1:0]    cnt_inc;
    logic [LEN_W-1:0]    need_ext;
    logic                surplus;
    logic                drop;
    logic                matched_inc;
    logic [MATCH_W-1:0]  matched_new;
    logic                covered;
    logic                result_load;
    logic                stream_clear;

    assign cnt_inc     = cnt_rd_data + 1'b1;
    assign need_ext    = LEN_W'(need_cnt);
    assign surplus     = cnt_rd_data > need_ext;
    assign drop        = surplus || (need_cnt == '0);
    assign matched_inc = (need_cnt != '0) && (cnt_inc <= need_ext);
    assign matched_new = matched_reg + MATCH_W'(matched_inc);
    assign covered     = (eff_size_reg != '0) && (matched_new >= eff_size_reg);

    // read the new byte's count at accept, the left byte's count while scanning
    assign cnt_rd_addr = (state_reg == S_IDLE) ? sym_in : byte_reg;
    assign cnt_wr_addr = (state_reg == S_ADD) ? sym_reg : byte_reg;
    assign cnt_wr_data = (state_reg == S_ADD) ? cnt_inc : (cnt_rd_data - 1'b1);

    assign result_load  = (state_reg == S_DONE) && last_reg &&
                          (!out_valid_reg || m_tready);
    assign stream_clear = cfg_wr || result_load;

    assign cnt_ctrl.wr_en = (state_reg == S_ADD) ||
                            ((state_reg == S_CHECK) && surplus);
    assign cnt_ctrl.clear = stream_clear;

    scwf_count_store #(
        .DEPTH  (ALPHABET),
        .ADDR_W (SYM_W),
        .CNT_W  (LEN_W)
    ) u_count_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cnt_ctrl),
        .rd_addr (cnt_rd_addr),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_data (cnt_rd_data)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sym_reg        <= '0;
            last_reg       <= 1'b0;
            position_reg   <= '0;
            left_edge_reg  <= '0;
            win_len_reg    <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            matched_reg    <= '0;
            best_start_reg <= '0;
            best_len_reg   <= LEN_NONE;
            overflowed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= scwf_pkg::STATUS_NONE;
            out_start_reg  <= '0;
            out_len_reg    <= '0;
        end
        else
        begin
            // load a new result or drop the one just taken
            if (result_load && !cfg_wr)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr)
            begin
                state_reg <= S_IDLE;
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (accept)
                        begin
                            sym_reg  <= sym_in;
                            last_reg <= s_tlast;
                            if (ovf_now)
                            begin
                                // hold overflow and ignore bytes until the last one
                                overflowed_reg <= 1'b1;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                wr_ptr_reg   <= (wr_ptr_reg == PTR_LAST) ?
                                                '0 : wr_ptr_reg + 1'b1;
                                position_reg <= position_reg + 1'b1;
                                win_len_reg  <= win_len_reg + 1'b1;
                                state_reg    <= S_ADD;
                            end
                        end
                    end
                    S_ADD:
                    begin
                        matched_reg <= matched_new;
                        state_reg   <= covered ? S_SCAN : S_DONE;
                    end
                    S_SCAN:
                    begin
                        state_reg <= (win_len_reg == '0) ? S_BEST : S_FETCH;
                    end
                    S_FETCH:
                    begin
                        state_reg <= S_CHECK;
                    end
                    S_CHECK:
                    begin
                        if (drop)
                        begin
                            // advance the left edge past a surplus or unneeded byte
                            rd_ptr_reg    <= (rd_ptr_reg == PTR_LAST) ?
                                             '0 : rd_ptr_reg + 1'b1;
                            left_edge_reg <= left_edge_reg + 1'b1;
                            win_len_reg   <= win_len_reg - 1'b1;
                            state_reg     <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_BEST;
                        end
                    end
                    S_BEST:
                    begin
                        // strict compare keeps the earliest of equal windows
                        if (LENGTH_W'(win_len_reg) < best_len_reg)
                        begin
                            best_len_reg   <= LENGTH_W'(win_len_reg);
                            best_start_reg <= START_W'(left_edge_reg);
                        end
                        state_reg <= S_DONE;
                    end
                    S_DONE:
                    begin
                        if (!last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (result_load)
                        begin
                            if (overflowed_reg)
                            begin
                                out_status_reg <= scwf_pkg::STATUS_OVERFLOW;
                                out_start_reg  <= '0;
                                out_len_reg    <= '0;
                            end
                            else if (best_len_reg == LEN_NONE)
                            begin
                                out_status_reg <= scwf_pkg::STATUS_NONE;
                                out_start_reg  <= '0;
                                out_len_reg    <= '0;
                            end
                            else
                            begin
                                out_status_reg <= scwf_pkg::STATUS_FOUND;
                                out_start_reg  <= best_start_reg;
                                out_len_reg    <= best_len_reg;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end

            // drop the string in progress after a result or a register write
            if (stream_clear)
            begin
                position_reg   <= '0;
                left_edge_reg  <= '0;
                win_len_reg    <= '0;
                wr_ptr_reg     <= '0;
                rd_ptr_reg     <= '0;
                matched_reg    <= '0;
                best_start_reg <= '0;
                best_len_reg   <= LEN_NONE;
                overflowed_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = scwf_pkg::OUT_DATA_W'({out_len_reg, out_start_reg, out_status_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SCWF_ASSERT(a_window_fits_ring, win_len_reg <= DEPTH_LEN)
    `SCWF_ASSERT(a_matched_bounded, matched_reg <= eff_size_reg)
    `SCWF_ASSERT_IMPL(a_scan_only_when_covered, state_reg == S_SCAN,
        (eff_size_reg != '0) && (matched_reg >= eff_size_reg))
    `SCWF_ASSERT_IMPL(a_empty_result_fields,
        m_tvalid && (out_status_reg != scwf_pkg::STATUS_FOUND),
        (out_start_reg == '0) && (out_len_reg == '0))

endmodule

// ----- hw/rtl/scwf_count_store.sv -----
// Per-symbol count memory with one valid flop per entry, so a clear is instant.
// Depends on scwf_pkg for the control struct.
module scwf_count_store #(
    parameter int unsigned DEPTH  = scwf_pkg::ALPHABET_DEF,
    parameter int unsigned ADDR_W = $clog2(DEPTH),
    parameter int unsigned CNT_W  = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  scwf_pkg::cnt_ctrl_t   ctrl,
    input  logic [ADDR_W-1:0]     rd_addr,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [CNT_W-1:0]      wr_data,
    output logic [CNT_W-1:0]      rd_data
);

    logic [CNT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0] rd_val_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_val_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (ctrl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // An entry never written since the last clear reads as zero.
    assign rd_data = rd_valid_reg ? rd_val_reg : '0;

endmodule
